// ===== rtl/core/rqia_pkg.sv =====
// ----------------------------------------------------------------------------
// rqia_pkg
// Shared types, request codes and pointer helpers for the ring queue.
// ----------------------------------------------------------------------------
package rqia_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CAP_W   = 5;
  localparam int IDX_W   = 4;
  localparam int BUS_W   = 32;
  localparam int REQ_W   = 2;
  localparam int ARITH_W = CAP_W + 1;

  localparam int CAP_RESET = 16;

  typedef logic [REQ_W-1:0]   req_type_t;
  typedef logic [BUS_W-1:0]   bus_word_t;
  typedef logic [IDX_W-1:0]   index_t;
  typedef logic [CAP_W-1:0]   cap_t;
  typedef logic [ARITH_W-1:0] arith_t;

  localparam req_type_t REQ_PUSH   = 2'd0;
  localparam req_type_t REQ_POP    = 2'd1;
  localparam req_type_t REQ_PEEK   = 2'd2;
  localparam req_type_t REQ_DELETE = 2'd3;

  // Advance a pointer by one slot, wrapping at the slot count.
  function automatic arith_t step_up(arith_t p, cap_t c);
    arith_t n;
    n = p + arith_t'(1);
    if (n >= arith_t'(c)) begin
      n = n - arith_t'(c);
    end
    return n;
  endfunction

  // Pointer plus a logical offset below the slot count, wrapped once.
  function automatic arith_t offset(arith_t p, index_t k, cap_t c);
    arith_t n;
    n = p + arith_t'(k);
    if (n >= arith_t'(c)) begin
      n = n - arith_t'(c);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/rqia_ifs.sv =====
// ----------------------------------------------------------------------------
// rqia request and response channels
// Valid/ready channels that carry one request or one response per transaction.
// ----------------------------------------------------------------------------
interface rqia_req_if;
  import rqia_pkg::*;

  logic      valid;
  logic      ready;
  req_type_t req_type;
  bus_word_t data_in;
  index_t    index;

  modport source (output valid, output req_type, output data_in, output index,
                  input ready);
  modport sink   (input valid, input req_type, input data_in, input index,
                  output ready);
endinterface

interface rqia_rsp_if;
  import rqia_pkg::*;

  logic      valid;
  logic      ready;
  logic      status;
  bus_word_t data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink   (input valid, input status, input data_out, output ready);
endinterface

// ===== rtl/core/rqia_ram.sv =====
// ----------------------------------------------------------------------------
// rqia_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rqia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ring_queue_with_indexed_access.sv =====
// ----------------------------------------------------------------------------
// ring_queue_with_indexed_access
// Circular queue with push, pop, peek at index and delete at index.
// ----------------------------------------------------------------------------
// The block handles one request at a time and returns exactly one response per
// request. A push, or any request that fails, goes straight to the response
// state; a pop or a peek that succeeds first passes through a RAM read state;
// and a delete first moves the occupancy - index - 1 words behind the deleted
// one through the single RAM write port at one word per cycle. A new request
// is taken as soon as the previous one has handed its response to the output
// register, even if that response has not yet been taken. A write of the
// capacity register empties the queue; a capacity of zero means one slot and
// values above DEPTH mean DEPTH slots.
module ring_queue_with_indexed_access #(
  parameter int DEPTH      = rqia_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rqia_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [rqia_pkg::CAP_W-1:0] cfg_wdata,
  rqia_req_if.sink              req,
  rqia_rsp_if.source            rsp
);
  import rqia_pkg::*;

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam int CAP_RST = (CAP_RESET < CAP_MAX) ? CAP_RESET : CAP_MAX;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_MOVE = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]            state;
  cap_t                  slots;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  cap_t                  occ;
  logic [PTR_W-1:0]      cur_dst;
  logic [PTR_W-1:0]      cur_src;
  cap_t                  moves;
  logic                  res_status;
  bus_word_t             res_data;
  logic                  out_valid;
  logic                  out_status;
  bus_word_t             out_data;

  logic                  accept;
  logic                  out_free;
  logic                  idx_bad;
  arith_t                peek_pos;
  arith_t                del_src;
  cap_t                  del_moves;
  logic [PTR_W-1:0]      tail_back;
  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [PTR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign req.ready    = (state == ST_IDLE);
  assign accept       = req.valid && req.ready;
  assign out_free     = !out_valid || rsp.ready;
  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.data_out = out_data;

  assign idx_bad   = (cap_t'(req.index) >= occ);
  assign peek_pos  = offset(arith_t'(head), req.index, slots);
  assign del_src   = step_up(peek_pos, slots);
  assign del_moves = occ - cap_t'(req.index) - cap_t'(1);
  assign tail_back = (tail == '0) ? PTR_W'(slots - cap_t'(1)) : tail - PTR_W'(1);

  always_comb begin
    ram_raddr = PTR_W'(step_up(arith_t'(cur_src), slots));
    if (state == ST_IDLE) begin
      case (req.req_type)
        REQ_POP:    ram_raddr = head;
        REQ_PEEK:   ram_raddr = PTR_W'(peek_pos);
        REQ_DELETE: ram_raddr = PTR_W'(del_src);
        default:    ram_raddr = head;
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = DATA_WIDTH'(req.data_in);
    if (state == ST_MOVE) begin
      ram_we    = 1'b1;
      ram_waddr = cur_dst;
      ram_wdata = ram_rdata;
    end else if (accept && req.req_type == REQ_PUSH && occ < slots) begin
      ram_we = 1'b1;
    end
  end

  rqia_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slots     <= cap_t'(CAP_RST);
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          slots <= cap_t'(1);
        end else if (int'(cfg_wdata) > CAP_MAX) begin
          slots <= cap_t'(CAP_MAX);
        end else begin
          slots <= cfg_wdata;
        end
        head <= '0;
        tail <= '0;
        occ  <= '0;
      end

      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_status <= 1'b0;
            res_data   <= '0;
            state      <= ST_RESP;
            case (req.req_type)
              REQ_PUSH: begin
                if (occ >= slots) begin
                  res_status <= 1'b1;
                end else begin
                  tail <= PTR_W'(step_up(arith_t'(tail), slots));
                  occ  <= occ + cap_t'(1);
                end
              end
              REQ_POP: begin
                if (occ == '0) begin
                  res_status <= 1'b1;
                end else begin
                  head  <= PTR_W'(step_up(arith_t'(head), slots));
                  occ   <= occ - cap_t'(1);
                  state <= ST_READ;
                end
              end
              REQ_PEEK: begin
                if (idx_bad) begin
                  res_status <= 1'b1;
                end else begin
                  state <= ST_READ;
                end
              end
              default: begin
                if (idx_bad) begin
                  res_status <= 1'b1;
                end else if (del_moves == '0) begin
                  tail <= tail_back;
                  occ  <= occ - cap_t'(1);
                end else begin
                  cur_dst <= PTR_W'(peek_pos);
                  cur_src <= PTR_W'(del_src);
                  moves   <= del_moves;
                  state   <= ST_MOVE;
                end
              end
            endcase
          end
        end
        ST_READ: begin
          res_data <= BUS_W'(ram_rdata);
          state    <= ST_RESP;
        end
        ST_MOVE: begin
          if (moves == cap_t'(1)) begin
            tail  <= tail_back;
            occ   <= occ - cap_t'(1);
            state <= ST_RESP;
          end else begin
            moves   <= moves - cap_t'(1);
            cur_dst <= cur_src;
            cur_src <= PTR_W'(step_up(arith_t'(cur_src), slots));
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_data   <= res_data;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
